[sv/lcl_pkg.sv]
`timescale 1ns / 1ps

package lcl_pkg;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CAP_BITS   = 5;

  localparam int unsigned AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(ENTRIES);

  typedef struct packed {
    logic                  en;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } lcl_req_t;

endpackage

[sv/lcl_store.sv]
`timescale 1ns / 1ps

module lcl_store
  import lcl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lcl_req_t            req_i,
  input  logic [CMP_W-1:0]    eff_cap_i,
  output logic                hit_o
);

  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [AGE_W-1:0]      age_q [ENTRIES];
  logic [AGE_W-1:0]      age_d [ENTRIES];
  logic [KEY_BITS-1:0]   key_q [ENTRIES];
  logic [VALUE_BITS-1:0] value_q [ENTRIES];

  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] evict_vec;
  logic [ENTRIES-1:0] kept;
  logic [ENTRIES-1:0] free_vec;
  logic [ENTRIES-1:0] slot_oh;
  logic [AGE_W-1:0]   hit_age;
  logic [AGE_W-1:0]   oldest;
  logic [CNT_W-1:0]   count;
  logic               full;
  logic               hit;

  always_comb begin
    hit_vec = '0;
    hit_age = '0;
    count   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = valid_q[i] && (key_q[i] == req_i.key);
      hit_age    = hit_age | (hit_vec[i] ? age_q[i] : '0);
      count      = count + CNT_W'(valid_q[i]);
    end
    hit    = |hit_vec;
    oldest = AGE_W'(count - CNT_W'(1));
    full   = (CMP_W'(count) >= eff_cap_i);
    for (int i = 0; i < ENTRIES; i++) begin
      evict_vec[i] = full && valid_q[i] && (age_q[i] == oldest);
    end
    kept     = valid_q & ~evict_vec;
    free_vec = ~kept;
    slot_oh  = free_vec & (~free_vec + ENTRIES'(1));
  end

  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    if (req_i.en) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (hit_vec[i]) begin
            age_d[i] = '0;
          end else if (valid_q[i] && (age_q[i] < hit_age)) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
      end else begin
        valid_d = kept | slot_oh;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_oh[i]) begin
            age_d[i] = '0;
          end else if (kept[i]) begin
            age_d[i] = age_q[i] + AGE_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

  // tag and data array
  always_ff @(posedge clk_i) begin
    if (req_i.en && !hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_oh[i]) begin
          key_q[i]   <= req_i.key;
          value_q[i] <= req_i.value;
        end
      end
    end
  end

  assign hit_o = hit;

endmodule

[sv/lru_cache_lookup.sv]
`timescale 1ns / 1ps

// Fully associative 16-entry cache with least-recently-used replacement. Each input beat
// carries a key and a value; one output beat follows with hit_o set when the key was
// present. A miss inserts the key as most recent, evicting the least recent entry once the
// number of valid entries reaches the capacity register (0 acts as 1, above 16 acts as 16).
// An accepted beat sits in an input register, where the parallel tag match and age update
// run and commit when the beat advances, then lands in an output register: a beat can be
// taken every cycle while the output is not stalled.
// The throughput is one beat per cycle, bounded by the combinational match and age update.
// All entries are invalid after reset; write cfg_wdata_i only while no beat is in flight.

module lru_cache_lookup
  import lcl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CAP_BITS-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [KEY_BITS-1:0]   lookup_key_i,
  input  logic [VALUE_BITS-1:0] insert_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  hit_o
);

  logic [CAP_BITS-1:0]   cap_q;
  logic                  in_valid_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  out_valid_q;
  logic                  hit_q;
  logic                  advance;
  logic                  accept;
  logic                  hit;
  logic [CMP_W-1:0]      eff_cap;
  lcl_req_t              req;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  always_comb begin
    req.en    = advance;
    req.key   = key_q;
    req.value = value_q;
  end

  lcl_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .eff_cap_i (eff_cap),
    .hit_o     (hit)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q   <= lookup_key_i;
      value_q <= insert_value_i;
    end
    if (advance) begin
      hit_q <= hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

endmodule

[sv/lcl_checker.sv]
`timescale 1ns / 1ps

module lcl_checker
  import lcl_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);

  logic [1:0] inflight_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 2'(in_beat) - 2'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_hit_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(hit_o))
    else $error("hit changed while stalled");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream back-pressure");

  a_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q != 2'd3) && (!out_valid_o || (inflight_q != 2'd0)))
    else $error("beat count mismatch between input and output");

endmodule

bind lru_cache_lookup lcl_checker u_lcl_checker (.*);
